### design/fpr_pkg.sv
// fpr_pkg: shared types and constants for the framed packet receiver
// no dependencies
package fpr_pkg;

  localparam int BYTE_W     = 8;
  localparam int TIME_W     = 16;
  localparam int MAXP_W     = 6;
  localparam int IDX_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LEN_BYTE_POS = 2;
  localparam int BODY_OFFSET  = LEN_BYTE_POS + 2;
  localparam int MAX_OUT      = 64;

  localparam logic [MAXP_W-1:0] PAYLOAD_LIMIT = 6'd60;
  localparam logic [MAXP_W-1:0] MAXP_RESET    = 6'd60;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TIME = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    PH_INFO,
    PH_ADDR,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SHOW
  } emit_state_t;

  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_MAX_PAYLOAD = 2'd0;
  localparam cfg_index_t CFG_TIMEOUT     = 2'd1;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] last_idx;
  } emit_req_t;

endpackage

### design/framed_packet_receiver.sv
// framed_packet_receiver: a byte or time request is taken while in_stall is low; a good
// checksum byte starts emission: the request is registered, then the store is read and
// the first frame byte shown; each later byte takes a store read then an output step,
// held while out_stall is high; input stalls until the last byte has been taken.
// reset clears parser state, idle timer, emitter and config (max_payload 60, timeout 1000);
// the frame store is not cleared, every byte emitted is written earlier in its frame.
// depends on fpr_pkg, fpr_ram, fpr_rx_ctrl, fpr_emit
module framed_packet_receiver #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [fpr_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [fpr_pkg::TIME_W-1:0]     elapsed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fpr_pkg::BYTE_W-1:0]     frame_byte,
  output logic [fpr_pkg::IDX_W-1:0]      byte_index,
  output logic                           last_byte,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);

  logic [MAXP_W-1:0] max_payload;
  logic [TIME_W-1:0] timeout_limit;
  logic [MAXP_W-1:0] maxp_wr;
  logic              cfg_wr;

  logic              ram_we, ram_re, emit_busy;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;
  emit_req_t         emit_req;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign maxp_wr   = (cfg_data[MAXP_W-1:0] > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT
                                                            : cfg_data[MAXP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= MAXP_RESET;
      timeout_limit <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: max_payload   <= maxp_wr;
        CFG_TIMEOUT:     timeout_limit <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = emit_busy || emit_req.start;

  fpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fpr_rx_ctrl #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_rx_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .hold          (in_stall),
    .opcode        (opcode),
    .rx_byte       (rx_byte),
    .elapsed       (elapsed),
    .max_payload   (max_payload),
    .timeout_limit (timeout_limit),
    .we            (ram_we),
    .waddr         (ram_waddr),
    .wdata         (ram_wdata),
    .emit_req      (emit_req)
  );

  fpr_emit #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .emit_req   (emit_req),
    .busy       (emit_busy),
    .re         (ram_re),
    .raddr      (ram_raddr),
    .rdata      (ram_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .byte_index (byte_index),
    .last_byte  (last_byte)
  );

endmodule

### design/fpr_ram.sv
// fpr_ram: generic single write port, single read port ram with registered read
// no dependencies
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/fpr_rx_ctrl.sv
// fpr_rx_ctrl: frame parser, checksum, idle timer and frame store writes
// depends on fpr_pkg
module fpr_rx_ctrl #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             hold,
  input  logic                             opcode,
  input  logic [fpr_pkg::BYTE_W-1:0]       rx_byte,
  input  logic [fpr_pkg::TIME_W-1:0]       elapsed,
  input  logic [fpr_pkg::MAXP_W-1:0]       max_payload,
  input  logic [fpr_pkg::TIME_W-1:0]       timeout_limit,
  output logic                             we,
  output logic [$clog2(FRAME_DEPTH)-1:0]   waddr,
  output logic [fpr_pkg::BYTE_W-1:0]       wdata,
  output fpr_pkg::emit_req_t               emit_req
);
  import fpr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam logic [AW-1:0] FILL_MAX = AW'(FRAME_DEPTH - 1);

  phase_t            phase, phase_next;
  logic [AW-1:0]     fill, fill_next, fill_base, fill_after;
  logic [BYTE_W-1:0] sum, sum_next, sum_base;
  logic [BYTE_W-1:0] len, len_next;
  logic [TIME_W-1:0] idle, idle_next;
  logic [TIME_W:0]   idle_sum;
  logic              accept, byte_acc, time_acc, len_ok, frame_done, timeout;
  emit_req_t         emit_req_next;

  assign accept    = in_valid && !hold;
  assign byte_acc  = accept && (opcode == OP_BYTE);
  assign time_acc  = accept && (opcode == OP_TIME);
  assign len_ok    = rx_byte <= {2'b00, max_payload};
  assign fill_base = (phase == PH_INFO) ? '0 : fill;
  assign sum_base  = (phase == PH_INFO) ? '0 : sum;
  assign fill_after = (fill_base != FILL_MAX) ? fill_base + 1'b1 : fill_base;
  assign frame_done = (phase == PH_BODY)
                   && (32'(fill_after) >= 32'(BODY_OFFSET))
                   && (32'(len) == 32'(fill_after) - 32'(BODY_OFFSET));
  assign idle_sum = {1'b0, idle} + {1'b0, elapsed};
  assign timeout  = (idle < timeout_limit) && (idle_sum >= {1'b0, timeout_limit});

  always_comb begin
    phase_next = phase;
    if (byte_acc) begin
      unique case (phase)
        PH_INFO: phase_next = PH_ADDR;
        PH_ADDR: phase_next = PH_LEN;
        PH_LEN:  phase_next = len_ok ? PH_BODY : PH_INFO;
        PH_BODY: phase_next = frame_done ? PH_INFO : PH_BODY;
        default: phase_next = PH_INFO;
      endcase
    end else if (time_acc && timeout) begin
      phase_next = PH_INFO;
    end
  end

  always_comb begin
    fill_next     = fill;
    sum_next      = sum;
    len_next      = len;
    idle_next     = idle;
    we            = 1'b0;
    waddr         = fill_base;
    wdata         = rx_byte;
    emit_req_next = '0;
    if (byte_acc) begin
      idle_next = '0;
      we = (phase != PH_LEN) || len_ok;
      if (we) begin
        fill_next = fill_after;
        sum_next  = sum_base + rx_byte;
      end
      if (phase == PH_LEN && len_ok) begin
        len_next = rx_byte;
      end
      if (frame_done && rx_byte == sum) begin
        emit_req_next.start    = 1'b1;
        emit_req_next.last_idx = (32'(fill_after) > 32'(MAX_OUT)) ? IDX_W'(MAX_OUT - 1)
                                                                   : IDX_W'(fill_after - 1'b1);
      end
    end else if (time_acc && idle < timeout_limit) begin
      idle_next = (idle_sum > {1'b0, timeout_limit}) ? timeout_limit
                                                     : idle_sum[TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_INFO;
      fill     <= '0;
      sum      <= '0;
      idle     <= '0;
      emit_req <= '0;
    end else begin
      phase    <= phase_next;
      fill     <= fill_next;
      sum      <= sum_next;
      idle     <= idle_next;
      emit_req <= emit_req_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_MAX)
    else $error("fill index beyond frame store");

  a_start_from_body: assert property (@(posedge clk) disable iff (rst)
    byte_acc && frame_done && rx_byte == sum |=> emit_req.start && phase == PH_INFO)
    else $error("good frame did not request emission");

endmodule

### design/fpr_emit.sv
// fpr_emit: reads a finished frame out of the frame store, one whole frame per request
// depends on fpr_pkg
module fpr_emit #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fpr_pkg::emit_req_t             emit_req,
  output logic                           busy,
  output logic                           re,
  output logic [$clog2(FRAME_DEPTH)-1:0] raddr,
  input  logic [fpr_pkg::BYTE_W-1:0]     rdata,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fpr_pkg::BYTE_W-1:0]     frame_byte,
  output logic [fpr_pkg::IDX_W-1:0]      byte_index,
  output logic                           last_byte
);
  import fpr_pkg::*;

  localparam int AW = $clog2(FRAME_DEPTH);

  emit_state_t      state, state_next;
  logic [IDX_W-1:0] k, k_next;
  logic [IDX_W-1:0] last_idx, last_idx_next;
  logic             at_last;

  assign at_last = (k == last_idx);

  always_comb begin
    state_next = state;
    unique case (state)
      EM_IDLE: if (emit_req.start) state_next = EM_SHOW;
      EM_READ: state_next = EM_SHOW;
      EM_SHOW: if (!out_stall) state_next = at_last ? EM_IDLE : EM_READ;
      default: state_next = EM_IDLE;
    endcase
  end

  always_comb begin
    re            = 1'b0;
    raddr         = AW'(k);
    k_next        = k;
    last_idx_next = last_idx;
    out_valid     = 1'b0;
    unique case (state)
      EM_IDLE: begin
        if (emit_req.start) begin
          re            = 1'b1;
          raddr         = '0;
          k_next        = '0;
          last_idx_next = emit_req.last_idx;
        end
      end
      EM_READ: re = 1'b1;
      EM_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall && !at_last) begin
          k_next = k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state != EM_IDLE);
  assign frame_byte = rdata;
  assign byte_index = k;
  assign last_byte  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= EM_IDLE;
      k        <= '0;
      last_idx <= '0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      last_idx <= last_idx_next;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    emit_req.start |-> state == EM_IDLE)
    else $error("emission requested while busy");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> k <= last_idx)
    else $error("byte index ran past frame end");

endmodule

### tb/framed_packet_receiver_checker.sv
// framed_packet_receiver_checker: watches the request, result and register channels,
// predicts the emitted frame bytes and compares them in order.
// depends on fpr_pkg
module framed_packet_receiver_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           opcode,
  input  logic [fpr_pkg::BYTE_W-1:0]     rx_byte,
  input  logic [fpr_pkg::TIME_W-1:0]     elapsed,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [fpr_pkg::BYTE_W-1:0]     frame_byte,
  input  logic [fpr_pkg::IDX_W-1:0]      byte_index,
  input  logic                           last_byte,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpr_pkg::*;

  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } frame_out_t;

  frame_out_t        frame_bytes_due[$];
  logic [BYTE_W-1:0] frame_mem [STORE_DEPTH];
  phase_t            rx_phase;
  logic [IDX_W-1:0]  fill;
  logic [BYTE_W-1:0] run_sum;
  logic [TIME_W-1:0] idle_t;
  logic [MAXP_W-1:0] max_len;
  logic [TIME_W-1:0] timeout;

  function automatic void store_rx(logic [BYTE_W-1:0] b);
    frame_mem[fill] = b;
    run_sum = run_sum + b;
    if (fill < STORE_DEPTH - 1) fill = fill + 1'b1;
  endfunction

  function automatic void take_request(opcode_t op, logic [BYTE_W-1:0] b,
                                       logic [TIME_W-1:0] e);
    logic [TIME_W:0]   t;
    logic [BYTE_W-1:0] want;
    frame_out_t        r;
    if (op == OP_TIME) begin
      if (idle_t < timeout) begin
        t = idle_t + e;
        if (t > timeout) t = timeout;
        idle_t = t[TIME_W-1:0];
        if (idle_t >= timeout && rx_phase != PH_INFO) rx_phase = PH_INFO;
      end
      return;
    end
    idle_t = '0;
    case (rx_phase)
      PH_INFO: begin
        fill = '0;
        run_sum = '0;
        store_rx(b);
        rx_phase = PH_ADDR;
      end
      PH_ADDR: begin
        store_rx(b);
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b <= max_len) begin
          store_rx(b);
          rx_phase = PH_BODY;
        end else begin
          rx_phase = PH_INFO;
        end
      end
      default: begin
        want = run_sum;
        store_rx(b);
        if (fill >= BODY_OFFSET && frame_mem[LEN_BYTE_POS] == fill - BODY_OFFSET) begin
          rx_phase = PH_INFO;
          if (b == want) begin
            for (int k = 0; k < fill && k < MAX_OUT; k++) begin
              r.data = frame_mem[k];
              r.idx  = k[IDX_W-1:0];
              r.last = (k == fill - 1);
              frame_bytes_due.push_back(r);
            end
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    frame_out_t r;
    if (rst) begin
      rx_phase = PH_INFO;
      fill     = '0;
      run_sum  = '0;
      idle_t   = '0;
      max_len  = MAXP_RESET;
      timeout  = TIMEOUT_RESET;
      frame_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_PAYLOAD:
            max_len = cfg_data[MAXP_W-1:0] > PAYLOAD_LIMIT ? PAYLOAD_LIMIT
                                                           : cfg_data[MAXP_W-1:0];
          CFG_TIMEOUT: timeout = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected frame byte data %h idx %0d last %b",
                   $time, frame_byte, byte_index, last_byte);
          errors++;
        end else begin
          r = frame_bytes_due.pop_front();
          if (frame_byte !== r.data || byte_index !== r.idx || last_byte !== r.last) begin
            $display("%0t: mismatch, expected %h/%0d/%b, got %h/%0d/%b",
                     $time, r.data, r.idx, r.last, frame_byte, byte_index, last_byte);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) take_request(opcode_t'(opcode), rx_byte, elapsed);
    end
    pending = frame_bytes_due.size();
  end

endmodule

### tb/framed_packet_receiver_tb.sv
// framed_packet_receiver_tb: clock, reset, register writes and request stimulus with
// random gaps and result stalls; the checker beside the block judges the results.
// depends on fpr_pkg, framed_packet_receiver, framed_packet_receiver_checker
module framed_packet_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpr_pkg::*;

  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         FULL           = 1000;
  localparam cfg_index_t CFG_SPARE_2    = 2'd2;
  localparam cfg_index_t CFG_SPARE_3    = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  opcode    = OP_BYTE;
  logic [BYTE_W-1:0]     rx_byte   = '0;
  logic [TIME_W-1:0]     elapsed   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  cfg_index_t            cfg_index = CFG_MAX_PAYLOAD;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall, out_valid, last_byte, cfg_ready;
  logic [BYTE_W-1:0]     frame_byte;
  logic [IDX_W-1:0]      byte_index;
  int                    errors, pending;

  int   items_sent;
  int   cur_maxp = 60;
  int   cur_tmo  = 1000;
  bit   no_idle;
  bit   hold_rx;
  int   stall_run, clear_run, stall_pick;
  int   quiet_cycles;

  always #6 clk = ~clk;

  framed_packet_receiver i_dut (
    .clk, .rst, .in_valid, .in_stall, .opcode, .rx_byte, .elapsed,
    .out_valid, .out_stall, .frame_byte, .byte_index, .last_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  framed_packet_receiver_checker i_checker (
    .clk, .rst, .in_valid, .in_stall, .opcode, .rx_byte, .elapsed,
    .out_valid, .out_stall, .frame_byte, .byte_index, .last_byte,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  always begin
    @(negedge clk);
    if (hold_rx) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_rx = 1'b0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (clear_run > 0) begin
      out_stall <= 1'b0;
      clear_run--;
    end else begin
      out_stall <= 1'b0;
      stall_pick = $urandom_range(0, 99);
      clear_run = stall_pick < 10 ? $urandom_range(40, 150) : $urandom_range(0, 6);
      stall_run = stall_pick < 60 ? $urandom_range(1, 2) :
                  stall_pick < 95 ? $urandom_range(3, 8) : $urandom_range(15, 50);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  task automatic send_item(opcode_t op, logic [BYTE_W-1:0] b, logic [TIME_W-1:0] e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    opcode   <= op;
    rx_byte  <= b;
    elapsed  <= e;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] b);
    send_item(OP_BYTE, b, TIME_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_time(logic [TIME_W-1:0] e);
    send_item(OP_TIME, BYTE_W'($urandom_range(0, 255)), e);
  endtask

  // sends the first cut bytes of a frame with a random header and payload, length byte len
  task automatic send_frame(int len, bit bad, int cut);
    logic [BYTE_W-1:0] sum, b;
    int                total;
    sum = '0;
    total = len + BODY_OFFSET;
    for (int k = 0; k < total && k < cut; k++) begin
      if (k == LEN_BYTE_POS) b = BYTE_W'(len);
      else if (k == total - 1) b = bad ? sum + BYTE_W'($urandom_range(1, 255)) : sum;
      else b = BYTE_W'($urandom_range(0, 255));
      if (k > 0 && $urandom_range(0, 9) == 0)
        send_time(cur_tmo == 0 ? TIME_W'($urandom_range(0, 65535))
                               : TIME_W'($urandom_range(0, (cur_tmo - 1) / 2)));
      send_byte(b);
      sum = sum + b;
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [CFG_DATA_W-1:0] maxp_word, logic [CFG_DATA_W-1:0] tmo);
    drain_results();
    repeat (4) @(negedge clk);
    write_reg(CFG_MAX_PAYLOAD, maxp_word);
    write_reg(CFG_TIMEOUT, tmo);
    cur_maxp = maxp_word[MAXP_W-1:0] > PAYLOAD_LIMIT ? PAYLOAD_LIMIT : maxp_word[MAXP_W-1:0];
    cur_tmo  = tmo;
  endtask

  task automatic run_random(int quota);
    int first, r, len, lim;
    first = items_sent;
    lim = cur_maxp > 59 ? 59 : cur_maxp;
    while (items_sent - first < quota) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 80) len = $urandom_range(0, lim < 6 ? lim : 6);
      else if ($urandom_range(0, 99) < 90) len = $urandom_range(0, lim);
      else len = lim;
      if (r < 60 || (cur_tmo == 0 && r >= 76 && r < 90)) begin
        send_frame(len, 1'b0, FULL);
      end else if (r < 70) begin
        send_frame(len, 1'b1, FULL);
      end else if (r < 76) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(BYTE_W'($urandom_range(cur_maxp + 1, 255)));
      end else if (r < 83) begin
        send_frame(len, 1'b0, $urandom_range(1, len + BODY_OFFSET - 1));
        send_time(TIME_W'($urandom_range(cur_tmo, 65535)));
      end else if (r < 90) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
        send_time(TIME_W'($urandom_range(cur_tmo, 65535)));
      end else begin
        send_time($urandom_range(0, 1) ? TIME_W'($urandom_range(0, 65535))
                                       : TIME_W'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] hi, ha, hp;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom_range(0, 65535)));

    // idle timer with no frame open, then short good and bad frames
    send_time(16'd0);
    send_time(16'hFFFF);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
    send_byte(8'h00); send_byte(8'h80); send_byte(8'h01); send_byte(8'h55);
    send_byte(8'hD7);
    // length above the limit
    send_byte(8'hAA); send_byte(8'h55); send_byte(8'd61);
    send_byte(8'h01); send_byte(8'h02); send_byte(8'hFF);
    // timeout reached exactly mid-frame
    send_byte(8'h10); send_byte(8'h20);
    send_time(16'd999);
    send_time(16'd1);
    // long result hold while requests keep coming
    hold_rx = 1'b1;
    send_frame(2, 1'b0, FULL);
    // largest frame that fits, then one that overruns the store until timeout
    send_frame(59, 1'b0, FULL);
    send_byte(BYTE_W'($urandom_range(0, 255)));
    send_byte(BYTE_W'($urandom_range(0, 255)));
    send_byte(8'd60);
    repeat (64) send_byte(BYTE_W'($urandom_range(0, 255)));
    send_time(16'd1000);
    send_frame(3, 1'b0, FULL);

    // limit lowered below the idle time already counted
    hi = BYTE_W'($urandom_range(0, 255));
    ha = BYTE_W'($urandom_range(0, 255));
    hp = BYTE_W'($urandom_range(0, 255));
    send_byte(hi); send_byte(ha);
    send_time(16'd500);
    drain_results();
    repeat (4) @(negedge clk);
    write_reg(CFG_TIMEOUT, 16'd300);
    cur_tmo = 300;
    send_time(16'd10);
    send_byte(8'd1); send_byte(hp); send_byte(hi + ha + 8'd1 + hp);

    // zero timeout and an oversized payload limit
    set_limits(16'hFFFF, 16'd0);
    send_byte(hi); send_byte(ha);
    send_time(16'hFFFF);
    send_byte(8'd0); send_byte(hi + ha);
    set_limits({10'($urandom_range(0, 1023)), 6'd0}, 16'd0);
    send_frame(0, 1'b0, FULL);
    send_byte(hi); send_byte(ha); send_byte(8'd1);

    set_limits({10'($urandom_range(0, 1023)), 6'd60}, 16'd1000);
    run_random(4);
    set_limits({10'($urandom_range(0, 1023)), 6'd0}, 16'd1);
    run_random(4);
    set_limits({10'($urandom_range(0, 1023)), 6'd63}, 16'hFFFF);
    no_idle = 1'b1;
    run_random(4);
    no_idle = 1'b0;
    set_limits(CFG_DATA_W'($urandom_range(0, 65535)), TIME_W'($urandom_range(2, 400)));
    run_random(4);
    set_limits({10'($urandom_range(0, 1023)), 6'd9}, 16'd0);
    run_random(4);

    drain_results();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
